>>> hdl/sliding_window_anagram_match_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window anagram match unit
// Shared property forms, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SWAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/swam_pkg.sv
// ---------------------------------------------------------------------------
// swam_pkg
// Constants, command and error codes of the sliding window anagram matcher.
// ---------------------------------------------------------------------------
package swam_pkg;

    localparam int MAX_LEN  = 64;
    localparam int ALPHABET = 26;

    localparam int LETTER_W = 5;
    localparam int CMD_W    = 2;
    localparam int ERR_W    = 2;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int RING_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIFF_W   = LEN_W + 1;
    localparam int SLOT_W   = LEN_W + 1;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PATTERN = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_TOO_LONG   = 2'd1,
        ERR_AFTER_TEXT = 2'd2
    } t_err;

endpackage

>>> hdl/sliding_window_anagram_match_unit.sv
// ---------------------------------------------------------------------------
// sliding_window_anagram_match_unit
// Reports windows of a letter stream that are a rearrangement of a pattern.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): each item carries a command and a letter index.
//   A clear empties the pattern and the window, pattern items then load the
//   pattern one letter at a time, and text items slide through a window as
//   long as the pattern. Output stream (m_*): one item per input item with
//   the window match flag, the sticky found flag and an error code.
// Timing: an item's result shows on m_tvalid in the cycle after it is taken.
// Throughput: one item per cycle while no held result stalls the input.
//   Once a pattern is loaded, each valid text item updates the per-letter
//   difference counters in parallel lanes and one slot of a 64-entry
//   letter ring; the leaving letter is prefetched into a register, so the
//   ring read never sits in the item's path.
// Reset: i_rst_n (synchronous, low) empties pattern and window, the same as
//   a clear command. The ring needs no clearing pass.
// Stall: while m_tready is low a held result blocks s_tready; one result
//   register parts the two sides, so a new item is taken in the same cycle
//   that the held result leaves.
// ---------------------------------------------------------------------------
`include "sliding_window_anagram_match_unit_defines.svh"

module sliding_window_anagram_match_unit
    import swam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] cmd, [6:2] letter, [7] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] window_match, [1] found, [3:2] error
);

    // state
    logic signed [DIFF_W-1:0] r_diff [ALPHABET];
    logic signed [DIFF_W-1:0] n_diff [ALPHABET];
    logic [LEN_W-1:0]    r_plen, n_plen;
    logic [LEN_W-1:0]    r_fill, n_fill;
    logic [RING_W-1:0]   r_ring, n_ring;
    logic                r_text, n_text;
    logic                r_seen, n_seen;
    logic [LETTER_W-1:0] r_leave;
    logic [LETTER_W-1:0] ring_mem [MAX_LEN];

    // result register
    logic                r_out_valid;
    logic                r_match, n_match;
    logic                r_found;
    t_err                r_err, n_err;

    // decode
    logic                accept;
    t_cmd                cmd;
    logic [LETTER_W-1:0] letter;
    logic                letter_ok;
    logic                clr;
    logic                pat_upd;
    logic                text_upd;
    logic                full;
    logic                any_nonzero;
    logic [SLOT_W-1:0]   slot_sum;
    logic [RING_W-1:0]   n_slot;

    assign s_tready  = !r_out_valid || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = t_cmd'(s_tdata[CMD_W-1:0]);
    assign letter    = s_tdata[CMD_W +: LETTER_W];
    assign letter_ok = letter < LETTER_W'(ALPHABET);
    assign full      = r_fill >= r_plen;

    always_comb begin
        clr      = 1'b0;
        pat_upd  = 1'b0;
        text_upd = 1'b0;
        n_err    = ERR_NONE;
        if (accept) begin
            unique case (cmd)
                CMD_CLEAR: begin
                    clr = 1'b1;
                end
                CMD_PATTERN: begin
                    if (letter_ok) begin
                        priority if (r_text) begin
                            n_err = ERR_AFTER_TEXT;
                        end else if (r_plen >= LEN_W'(MAX_LEN)) begin
                            n_err = ERR_TOO_LONG;
                        end else begin
                            pat_upd = 1'b1;
                        end
                    end
                end
                CMD_TEXT: begin
                    text_upd = letter_ok && (r_plen != '0);
                end
                default: begin
                end
            endcase
        end
    end

    // per-letter lanes: entering letter +1, leaving letter -1, pattern letter -1
    always_comb begin
        any_nonzero = 1'b0;
        for (int k = 0; k < ALPHABET; k++) begin
            if (clr) begin
                n_diff[k] = '0;
            end else begin
                n_diff[k] = r_diff[k]
                    + DIFF_W'(text_upd && (letter == LETTER_W'(k)))
                    - DIFF_W'(text_upd && full && (r_leave == LETTER_W'(k)))
                    - DIFF_W'(pat_upd && (letter == LETTER_W'(k)));
            end
            any_nonzero = any_nonzero || (n_diff[k] != '0);
        end
    end

    always_comb begin
        n_plen  = r_plen;
        n_fill  = r_fill;
        n_ring  = r_ring;
        n_text  = r_text;
        n_seen  = r_seen;
        n_match = 1'b0;
        if (clr) begin
            n_plen = '0;
            n_fill = '0;
            n_ring = '0;
            n_text = 1'b0;
            n_seen = 1'b0;
        end
        if (pat_upd) begin
            n_plen = r_plen + 1'b1;
        end
        if (accept && cmd == CMD_TEXT && letter_ok) begin
            n_text = 1'b1;
        end
        if (text_upd) begin
            if (!full) begin
                n_fill = r_fill + 1'b1;
            end
            n_ring = (r_ring == RING_W'(MAX_LEN - 1)) ? '0 : r_ring + 1'b1;
            if (n_fill == r_plen && !any_nonzero) begin
                n_match = 1'b1;
                n_seen  = 1'b1;
            end
        end
    end

    // ring slot of the letter that leaves on the next text item
    always_comb begin
        slot_sum = SLOT_W'(n_ring) + SLOT_W'(MAX_LEN) - SLOT_W'(n_plen);
        if (slot_sum >= SLOT_W'(MAX_LEN)) begin
            slot_sum = slot_sum - SLOT_W'(MAX_LEN);
        end
        n_slot = slot_sum[RING_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (text_upd) begin
            ring_mem[r_ring] <= letter;
        end
        // forward the letter written this cycle when it is the next to leave
        if (text_upd && n_slot == r_ring) begin
            r_leave <= letter;
        end else begin
            r_leave <= ring_mem[n_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ALPHABET; k++) begin
                r_diff[k] <= '0;
            end
            r_plen      <= '0;
            r_fill      <= '0;
            r_ring      <= '0;
            r_text      <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_diff <= n_diff;
            r_plen <= n_plen;
            r_fill <= n_fill;
            r_ring <= n_ring;
            r_text <= n_text;
            r_seen <= n_seen;
            if (s_tready) begin
                r_out_valid <= s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_match <= n_match;
            r_found <= n_seen || (n_plen == '0);
            r_err   <= n_err;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(OUT_DATA_W - ERR_W - 2)'(0), r_err, r_found, r_match};

    `SWAM_ASSERT_NOW(a_fill_le_plen, 1'b1, r_fill <= r_plen, "window fill exceeds pattern length")
    `SWAM_ASSERT_NOW(a_match_full, r_out_valid && r_match, (r_fill == r_plen) && (r_plen != '0) && r_found, "match reported on a window that is not full")
    `SWAM_ASSERT_NOW(a_err_no_match, r_out_valid && (r_err != ERR_NONE), !r_match, "match reported with an error")
    `SWAM_ASSERT_NEXT(a_clear, accept && (cmd == CMD_CLEAR), (r_plen == '0) && (r_fill == '0) && !r_text && r_found && !r_match, "clear did not empty the matcher")

endmodule

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// Anagram match unit regression
// Streams directed and random clear, pattern and text items into the unit,
// predicts each result with a sliding-window letter-count model and checks
// every output item in order, under random idling and back-pressure.
// ---------------------------------------------------------------------------
module testbench
    import swam_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1700;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_LIMIT = 20000;

    typedef logic [LETTER_W-1:0] t_letter;

    typedef struct packed {
        logic window_match;
        logic found;
        t_err error;
    } t_match_result;

    class anagram_scoreboard;
        int            letter_diff[ALPHABET];
        int unsigned   differing;
        int unsigned   pattern_len;
        int unsigned   window_fill;
        int unsigned   ring_pos;
        t_letter       recent[MAX_LEN];
        bit            text_started;
        bit            match_seen;
        t_match_result expected_q[$];
        int            fail_count;

        function new();
            clear_state();
            fail_count = 0;
        endfunction

        function void clear_state();
            foreach (letter_diff[i]) letter_diff[i] = 0;
            differing    = 0;
            pattern_len  = 0;
            window_fill  = 0;
            ring_pos     = 0;
            text_started = 1'b0;
            match_seen   = 1'b0;
        endfunction

        function void bump(int unsigned idx, int delta);
            if (letter_diff[idx] == 0) differing++;
            if (letter_diff[idx] + delta == 0) differing--;
            letter_diff[idx] += delta;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(t_cmd c, t_letter l);
            t_match_result r;
            int unsigned   slot;
            r.window_match = 1'b0;
            r.error        = ERR_NONE;
            if (c == CMD_CLEAR) begin
                clear_state();
            end else if ((c == CMD_PATTERN || c == CMD_TEXT) && l < ALPHABET) begin
                if (c == CMD_PATTERN) begin
                    if (text_started) begin
                        r.error = ERR_AFTER_TEXT;
                    end else if (pattern_len >= MAX_LEN) begin
                        r.error = ERR_TOO_LONG;
                    end else begin
                        bump(l, -1);
                        pattern_len++;
                    end
                end else begin
                    text_started = 1'b1;
                    if (pattern_len > 0) begin
                        // drop the letter that leaves a full window
                        if (window_fill >= pattern_len) begin
                            slot = (ring_pos + MAX_LEN - pattern_len) % MAX_LEN;
                            bump(recent[slot], -1);
                        end else begin
                            window_fill++;
                        end
                        bump(l, 1);
                        recent[ring_pos] = l;
                        ring_pos = (ring_pos + 1) % MAX_LEN;
                        if (window_fill == pattern_len && differing == 0) begin
                            r.window_match = 1'b1;
                            match_seen     = 1'b1;
                        end
                    end
                end
            end
            r.found = match_seen || pattern_len == 0;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_match_result e;
            if (expected_q.size() == 0) begin
                $error("result item with nothing expected: tdata %h", d);
                fail_count++;
                return;
            end
            e = expected_q.pop_front();
            if (d[0] !== e.window_match) begin
                $error("window_match: expected %0d, actual %0d", e.window_match, d[0]);
                fail_count++;
            end
            if (d[1] !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, d[1]);
                fail_count++;
            end
            if (d[3:2] !== e.error) begin
                $error("error: expected %0d, actual %0d", e.error, d[3:2]);
                fail_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [1:0] cmd, [6:2] letter, [7] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [0] window_match, [1] found, [3:2] error

    anagram_scoreboard sb;
    int counted_items = 0;
    bit burst         = 1'b0;
    bit hold_req      = 1'b0;

    sliding_window_anagram_match_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input t_cmd c, input t_letter l);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, l, c};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_item(c, l);
        if (c == CMD_CLEAR || (c != CMD_UNUSED && l < ALPHABET)) counted_items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic maybe_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_item(CMD_UNUSED, t_letter'($urandom_range(0, 31)));
        end else if (r < 4) begin
            send_item(r == 2 ? CMD_PATTERN : CMD_TEXT,
                      t_letter'($urandom_range(ALPHABET, 31)));
        end
    endtask

    task automatic run_directed();
        send_item(CMD_CLEAR, 5'd31);
        send_item(CMD_TEXT, 5'd2);        // empty pattern: found stays high
        send_item(CMD_PATTERN, 5'd0);     // pattern after text
        send_item(CMD_CLEAR, 5'd0);
        send_item(CMD_UNUSED, 5'd31);
        send_item(CMD_PATTERN, 5'd26);
        send_item(CMD_TEXT, 5'd31);
        send_item(CMD_PATTERN, 5'd0);
        send_item(CMD_PATTERN, 5'd25);
        send_item(CMD_PATTERN, 5'd1);
        send_item(CMD_TEXT, 5'd25);       // window not yet full
        send_item(CMD_TEXT, 5'd1);
        send_item(CMD_TEXT, 5'd0);        // first match
        send_item(CMD_TEXT, 5'd25);       // slid window still matches
        send_item(CMD_TEXT, 5'd3);        // no match, found sticks
        send_item(CMD_PATTERN, 5'd2);
        send_item(CMD_UNUSED, 5'd0);
        send_item(CMD_CLEAR, 5'd17);
        send_item(CMD_PATTERN, 5'd7);
        send_item(CMD_TEXT, 5'd7);
        send_item(CMD_TEXT, 5'd8);
        send_item(CMD_TEXT, 5'd7);
    endtask

    task automatic run_sequence(input bit long_pattern);
        int      r, plen, tlen, base, span, emitted, j, k;
        t_letter pat[$];
        t_letter perm[$];
        t_letter tmp;
        r = $urandom_range(0, 99);
        if (long_pattern) plen = MAX_LEN + $urandom_range(1, 3);
        else if (r < 3) plen = 0;
        else if (r < 72) plen = $urandom_range(1, 6);
        else if (r < 88) plen = $urandom_range(7, 20);
        else if (r < 96) plen = $urandom_range(21, MAX_LEN);
        else plen = MAX_LEN + $urandom_range(1, 2);
        // narrow alphabets make matches frequent
        if ($urandom_range(0, 3) == 0) begin
            base = 0;
            span = ALPHABET;
        end else begin
            span = $urandom_range(1, 4);
            base = $urandom_range(0, ALPHABET - span);
        end
        if (long_pattern || $urandom_range(0, 9) != 0)
            send_item(CMD_CLEAR, t_letter'($urandom_range(0, 31)));
        for (k = 0; k < plen; k++) begin
            tmp = t_letter'(base + $urandom_range(0, span - 1));
            if (pat.size() < MAX_LEN) pat.push_back(tmp);
            maybe_noise();
            send_item(CMD_PATTERN, tmp);
        end
        if (plen == 0) tlen = $urandom_range(1, 8);
        else tlen = plen + $urandom_range(0, 2 * plen + 8);
        // long runs wrap the letter ring
        if ($urandom_range(0, 9) == 0) tlen += 80;
        emitted = 0;
        while (emitted < tlen) begin
            maybe_noise();
            if ($urandom_range(0, 99) < 3)
                send_item(CMD_PATTERN, t_letter'($urandom_range(0, ALPHABET - 1)));
            if (pat.size() > 0 && $urandom_range(0, 99) < 40) begin
                perm = pat;
                for (j = perm.size() - 1; j > 0; j--) begin
                    k       = $urandom_range(0, j);
                    tmp     = perm[j];
                    perm[j] = perm[k];
                    perm[k] = tmp;
                end
                foreach (perm[i]) send_item(CMD_TEXT, perm[i]);
                emitted += perm.size();
            end else begin
                send_item(CMD_TEXT, t_letter'(base + $urandom_range(0, span - 1)));
                emitted++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin : ready_control
        int run_len;
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            gap = pick_gap(1'b0);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int seq_idx;
        int drain;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_drained();
        seq_idx = 0;
        while (counted_items < ITEM_TARGET) begin
            burst = ($urandom_range(0, 4) == 0);
            // hold the output while the input keeps offering items
            if (seq_idx == 6) begin
                burst    = 1'b1;
                hold_req = 1'b1;
            end
            run_sequence(seq_idx == 0 || seq_idx == 6);
            if (seq_idx % 8 == 7) wait_drained();
            seq_idx++;
        end
        burst = 1'b0;
        s_tvalid <= 1'b0;
        for (drain = 0; drain < DRAIN_LIMIT && sb.pending() != 0; drain++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            $error("%0d expected result items never arrived", sb.pending());
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("sliding_window_anagram_match_unit regression: pass");
        end else begin
            $display("sliding_window_anagram_match_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("sliding_window_anagram_match_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/swam_pkg.sv
hdl/sliding_window_anagram_match_unit.sv
verif/testbench.sv
